// ===== src/aad_pkg.sv =====
// Package with the shared types, constants and helpers of the area-average downscaler.
package aad_pkg;

	localparam int MAX_SRC_WIDTH  = 640;
	localparam int MAX_SRC_HEIGHT = 400;
	localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);

	localparam int NUM_W   = 20;
	localparam int DEN_W   = 5;
	localparam int LANES   = 3;
	localparam int COORD_W = 13;

	// Corner mapping: four numerators, divided by 200 = 8*25 or 320 = 64*5. The
	// power-of-two factor is a shift; the odd factor is a reciprocal multiplication
	// that is exact for the numerator magnitudes the registers can produce.
	localparam int CORNERS     = 4;
	localparam int MAG_W       = 17;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 22;
	localparam logic [RECIP_W-1:0] RECIP_25 = 20'd167773;
	localparam logic [RECIP_W-1:0] RECIP_5  = 20'd838861;

	localparam logic [0:0] CMD_WRITE = 1'b0;
	localparam logic [0:0] CMD_READ  = 1'b1;

	localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CENTER_FIT    = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [9:0] src_col;
		logic [8:0] src_row;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [8:0] grid_col;
		logic [7:0] grid_row;
	} in_item_t;

	typedef struct packed {
		logic [15:0] red_avg;
		logic [15:0] green_avg;
		logic [15:0] blue_avg;
		logic [3:0]  pixel_count;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_MAP_WAIT,
		ST_CORNER,
		ST_WALK,
		ST_DRAIN,
		ST_AVG,
		ST_AVG_WAIT,
		ST_DONE
	} state_t;

	function automatic logic [ADDR_W-1:0] pixel_addr(input logic [9:0] col,
			input logic [8:0] row);
		pixel_addr = ADDR_W'(32'(row) * MAX_SRC_WIDTH + 32'(col));
	endfunction

endpackage

// ===== src/aad_store.sv =====
// Image store: one write port and one registered read port.
module aad_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [aad_pkg::ADDR_W-1:0] waddr,
	input  logic [23:0]               wdata,
	input  logic                      re,
	input  logic [aad_pkg::ADDR_W-1:0] raddr,
	output logic [23:0]               rdata
);
	import aad_pkg::*;

	logic [23:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/aad_divider.sv =====
// Bit-serial restoring divider with three lanes sharing one divisor.
module aad_divider (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [aad_pkg::LANES-1:0][aad_pkg::NUM_W-1:0] num,
	input  logic [aad_pkg::DEN_W-1:0]                    den,
	output logic                                         done,
	output logic [aad_pkg::LANES-1:0][aad_pkg::NUM_W-1:0] quot
);
	import aad_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0]                  cnt_q;
	logic                              done_q;
	logic [DEN_W-1:0]                  den_q;
	logic [LANES-1:0][NUM_W-1:0]       num_q;
	logic [LANES-1:0][DEN_W-1:0]       rem_q;
	logic [LANES-1:0][DEN_W:0]         rem_sh;
	logic [LANES-1:0]                  fits;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_sh[l] = {rem_q[l], num_q[l][NUM_W-1]};
			fits[l]   = rem_sh[l] >= {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			num_q <= num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			for (int l = 0; l < LANES; l++) begin
				num_q[l] <= {num_q[l][NUM_W-2:0], fits[l]};
				rem_q[l] <= fits[l] ? DEN_W'(rem_sh[l] - {1'b0, den_q})
					: rem_sh[l][DEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== src/area_average_downscaler_core.sv =====
// Top level of the area-average downscaler: control sequencer, window walk and result register.
//
// A pixel write (cmd 0) is stored at row*640+col of the image store.
// A read (cmd 1) maps its grid cell to a source window and returns the per-channel Q8.8
// mean and the pixel count, saturated at 15. The read maps both corners (numerators, a
// reciprocal multiplication for the division by 200 or 320, and the sign and widening of
// the corners), walks the window pixels through the single read port of the image store,
// drains the last read, starts the divider, lets a bit-serial division by the pixel count
// form the three means, and then loads the result. An empty window skips the division.
// While a read is in work, input is stalled; a finished result waits in the output
// register, and the next item can be taken in the cycle after the result is loaded.
// Configuration writes are always accepted and are meant to happen while the block is idle.
module area_average_downscaler_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  aad_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output aad_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data
);
	import aad_pkg::*;

	// Configuration registers.
	logic [9:0] width_q;
	logic [8:0] height_q;
	logic       center_q;

	state_t state_q, state_nx;

	logic [8:0] gx_q;
	logic [7:0] gy_q;

	// Window corners and walk position, signed source coordinates.
	logic signed [COORD_W-1:0] x1_q, x2_q, y1_q, y2_q, i_q, j_q;
	logic [11:0] sum_r_q, sum_g_q, sum_b_q;
	logic [4:0]  cnt_q;
	logic [CORNERS-1:0] neg_q;
	logic        rd_valid_s1;
	logic        out_valid_q;
	out_item_t   out_q;

	// Controls from the sequencer.
	logic div_start, map_start, avg_start, walk_step, load_out, accept, accept_read;

	assign cfg_ready = 1'b1;
	assign accept      = in_valid && !in_stall;
	assign accept_read = accept && (in_data.cmd == CMD_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd320;
			height_q <= 9'd200;
			center_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: height_q <= cfg_data[8:0];
				REG_CENTER_FIT:    center_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Image store write path: pixel writes go straight in when they land in the store.
	logic              st_we, st_re;
	logic [ADDR_W-1:0] st_raddr;
	logic [23:0]       st_rdata;

	assign st_we = accept && (in_data.cmd == CMD_WRITE)
		&& (32'(in_data.src_col) < MAX_SRC_WIDTH) && (32'(in_data.src_row) < MAX_SRC_HEIGHT);

	aad_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (pixel_addr(in_data.src_col, in_data.src_row)),
		.wdata ({in_data.red_in, in_data.green_in, in_data.blue_in}),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Corner numerators. The height decides the scale when 5*w < 8*h; the centering
	// offset then shifts the columns, otherwise it shifts the rows.
	logic               mode_h;
	logic [9:0]         scale;
	logic [9:0]         xa, xb;
	logic [8:0]         ya, yb;
	logic signed [21:0] offset, col_off, row_off;
	logic signed [21:0] n_x1, n_x2, n_y1, n_y2;
	logic signed [21:0] map_num [CORNERS];
	logic [21:0]        map_abs [CORNERS];
	logic [CORNERS-1:0][MAG_W-1:0]   mag_s1;
	logic [CORNERS-1:0][COORD_W-1:0] quot_s2;
	logic [RECIP_W-1:0]              recip;
	logic [MAG_W+RECIP_W-1:0]        prod [CORNERS];
	logic [LANES-1:0][NUM_W-1:0] div_num;
	logic [DEN_W-1:0]            div_den;
	logic                        div_done;
	logic [LANES-1:0][NUM_W-1:0] div_quot;

	assign mode_h  = (13'(width_q) * 13'd5) < (13'(height_q) * 13'd8);
	assign scale   = mode_h ? {1'b0, height_q} : width_q;
	assign xa      = {1'b0, gx_q};
	assign xb      = 10'(gx_q) + 10'd1;
	assign ya      = {1'b0, gy_q};
	assign yb      = 9'(gy_q) + 9'd1;
	assign offset  = $signed(22'(width_q) * 22'd100) - $signed(22'(height_q) * 22'd160);
	assign col_off = (center_q && mode_h) ? offset : 22'sd0;
	assign row_off = (center_q && !mode_h) ? -offset : 22'sd0;
	assign n_x1    = $signed(22'(xa) * 22'(scale)) + col_off;
	assign n_x2    = $signed(22'(xb) * 22'(scale)) + col_off;
	assign n_y1    = $signed(22'(ya) * 22'(scale)) + row_off;
	assign n_y2    = $signed(22'(yb) * 22'(scale)) + row_off;

	// The divisor is 200 = 8*25 when the height decides the scale, else 320 = 64*5.
	// The magnitude is shifted by the power-of-two factor in ST_MAP
	// and multiplied by the reciprocal of the odd factor in ST_MAP_WAIT.
	assign recip = mode_h ? RECIP_25 : RECIP_5;

	always_comb begin
		map_num[0] = n_x1;
		map_num[1] = n_y1;
		map_num[2] = n_x2;
		map_num[3] = n_y2;
		for (int l = 0; l < CORNERS; l++) begin
			map_abs[l] = map_num[l][21] ? $unsigned(-map_num[l]) : $unsigned(map_num[l]);
			prod[l]    = (MAG_W+RECIP_W)'(mag_s1[l]) * (MAG_W+RECIP_W)'(recip);
		end
	end

	// The divider forms the three means; the divisor is the pixel count.
	assign div_num[0] = {sum_r_q, 8'd0};
	assign div_num[1] = {sum_g_q, 8'd0};
	assign div_num[2] = {sum_b_q, 8'd0};
	assign div_den    = cnt_q;

	aad_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Signed corners from the unsigned quotients; C division truncates toward zero.
	logic signed [COORD_W-1:0] q_c [CORNERS];
	always_comb begin
		for (int l = 0; l < CORNERS; l++) begin
			q_c[l] = neg_q[l] ? -$signed(quot_s2[l]) : $signed(quot_s2[l]);
		end
	end

	// Window walk: one store read per pixel that lies in the image and the store.
	logic in_image, walk_last, row_last;
	assign in_image = !i_q[COORD_W-1] && !j_q[COORD_W-1]
		&& (i_q < $signed({3'd0, width_q})) && (j_q < $signed({4'd0, height_q}))
		&& (i_q < $signed(COORD_W'(MAX_SRC_WIDTH))) && (j_q < $signed(COORD_W'(MAX_SRC_HEIGHT)));
	assign row_last  = (j_q == y2_q - 1'b1);
	assign walk_last = row_last && (i_q == x2_q - 1'b1);
	assign st_re     = walk_step && in_image;
	assign st_raddr  = pixel_addr(i_q[9:0], j_q[8:0]);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept_read) state_nx = ST_MAP;
			ST_MAP:      state_nx = ST_MAP_WAIT;
			ST_MAP_WAIT: state_nx = ST_CORNER;
			ST_CORNER:   state_nx = ST_WALK;
			ST_WALK:     if (walk_last) state_nx = ST_DRAIN;
			ST_DRAIN:    state_nx = ST_AVG;
			ST_AVG:      state_nx = (cnt_q == 5'd0) ? ST_DONE : ST_AVG_WAIT;
			ST_AVG_WAIT: if (div_done) state_nx = ST_DONE;
			ST_DONE:     if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		map_start = (state_q == ST_MAP);
		avg_start = (state_q == ST_AVG) && (cnt_q != 5'd0);
		div_start = avg_start;
		walk_step = (state_q == ST_WALK);
		load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			rd_valid_s1 <= st_re;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_read) begin
			gx_q <= in_data.grid_col;
			gy_q <= in_data.grid_row;
		end
		if (map_start) begin
			for (int l = 0; l < CORNERS; l++) begin
				neg_q[l]  <= map_num[l][21];
				mag_s1[l] <= mode_h ? MAG_W'(map_abs[l] >> 3) : MAG_W'(map_abs[l] >> 6);
			end
		end
		if (state_q == ST_MAP_WAIT) begin
			for (int l = 0; l < CORNERS; l++) begin
				quot_s2[l] <= prod[l][RECIP_SHIFT +: COORD_W];
			end
		end
		if (state_q == ST_CORNER) begin
			// A window that would be empty on an axis is widened to one pixel.
			x1_q    <= q_c[0];
			y1_q    <= q_c[1];
			x2_q    <= (q_c[2] == q_c[0]) ? q_c[0] + 1'b1 : q_c[2];
			y2_q    <= (q_c[3] == q_c[1]) ? q_c[1] + 1'b1 : q_c[3];
			i_q     <= q_c[0];
			j_q     <= q_c[1];
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (walk_step) begin
				if (row_last) begin
					j_q <= y1_q;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (rd_valid_s1) begin
				sum_r_q <= sum_r_q + 12'(st_rdata[23:16]);
				sum_g_q <= sum_g_q + 12'(st_rdata[15:8]);
				sum_b_q <= sum_b_q + 12'(st_rdata[7:0]);
				cnt_q   <= cnt_q + 1'b1;
			end
		end
		if (load_out) begin
			if (cnt_q == 5'd0) begin
				out_q <= '0;
			end else begin
				out_q.red_avg     <= div_quot[0][15:0];
				out_q.green_avg   <= div_quot[1][15:0];
				out_q.blue_avg    <= div_quot[2][15:0];
				out_q.pixel_count <= cnt_q[4] ? 4'd15 : cnt_q[3:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A store read is only issued while the window is walked.
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> ($past(state_q) == ST_WALK))
		else $error("store read outside the window walk");

	// The result register is never overwritten while a result waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	// A window never holds more than sixteen pixels.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AVG) |-> (cnt_q <= 5'd16))
		else $error("window pixel count out of bounds");

	// The divider reports completion only while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_AVG_WAIT))
		else $error("divider finished outside a wait state");

endmodule
